### src/bhe_pkg.sv
// Shared constants for the backbone hydrogen-bond energy block.
// Holds field widths, register indexes, reset values and the atom pairing.
// Depends on nothing.
`default_nettype none
package bhe_pkg;

   localparam int COORD_WIDTH_DEF = 20;
   localparam int POS_W = 60;
   localparam int MASK_W = 4;
   localparam int ENERGY_W = 18;

   localparam int Q_W = 17;
   localparam int MIN_W = 16;
   localparam int THR_W = 18;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] REG_COULOMB = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DIST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd2;

   localparam logic [Q_W-1:0] Q_RESET = 17'd28557;
   localparam logic [MIN_W-1:0] MIN_RESET = 16'd512;
   localparam logic signed [THR_W-1:0] THR_RESET = -18'sd512;

   localparam logic signed [ENERGY_W-1:0] E_MAX = 18'sh1FFFF;
   localparam logic signed [ENERGY_W-1:0] E_MIN = 18'sh20000;

   // Atom slots: 0 carbon, 1 oxygen, 2 nitrogen, 3 hydrogen.
   // Lanes: 0 O-N, 1 O-H, 2 C-N, 3 C-H.
   localparam int NUM_ATOMS = 4;
   localparam int NUM_LANES = 4;
   localparam int LANE_A [NUM_LANES] = '{1, 1, 0, 0};
   localparam int LANE_B [NUM_LANES] = '{2, 3, 2, 3};
   localparam int LANE_ON = 0;
   localparam int LANE_OH = 1;
   localparam int LANE_CN = 2;
   localparam int LANE_CH = 3;

endpackage
`default_nettype wire

### src/backbone_hbond_energy_test.sv
// Top level of the backbone hydrogen-bond energy test.
// Fully pipelined: distances, square roots, divisions and energy sum.
// Depends on bhe_pkg.
`default_nettype none
// Usage:
// A word is taken at every rising edge where start is high; busy is always
// low, so a new acceptor/donor pair may enter in every cycle.
// Each word carries four packed atom positions and a presence mask.
// Exactly one result word comes out per input word, in order, marked by
// rsp_valid for one cycle; the receiver cannot stall the block.
// The pipeline has four front stages (capture, differences, squares, sums),
// one stage per root bit in the square-root pipeline, one stage per quotient
// bit in the divider pipeline, and one output stage. Throughput is one word
// per cycle.
// Configuration is written through the csr_ port while no word is in flight.
// Synchronous reset clears all valid bits and restores the register defaults;
// results in flight are dropped.
module backbone_hbond_energy_test #(
   parameter int COORD_WIDTH = bhe_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [bhe_pkg::POS_W-1:0]       req_acceptor_carbon,
   input  wire logic [bhe_pkg::POS_W-1:0]       req_acceptor_oxygen,
   input  wire logic [bhe_pkg::POS_W-1:0]       req_donor_nitrogen,
   input  wire logic [bhe_pkg::POS_W-1:0]       req_donor_hydrogen,
   input  wire logic [bhe_pkg::MASK_W-1:0]      req_atoms_present,
   output logic                                 rsp_valid,
   output logic                                 rsp_bonded,
   output logic                                 rsp_close_contact,
   output logic signed [bhe_pkg::ENERGY_W-1:0]  rsp_energy,
   input  wire logic                            csr_write_en,
   input  wire logic [bhe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bhe_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import bhe_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam int SQ_W = 2 * W;
   localparam int SW = 2 * W + 2;
   localparam int D_BITS = W + 1;
   localparam int RW = D_BITS + 3;
   localparam int NUM_W = Q_W + 11;
   localparam int DR_W = D_BITS + 1;
   localparam int SUM_W = NUM_W + 3;

   logic [Q_W-1:0] q_ff;
   logic [MIN_W-1:0] min_ff;
   logic signed [THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= Q_RESET;
         min_ff <= MIN_RESET;
         thr_ff <= THR_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_COULOMB: q_ff <= csr_write_data[Q_W-1:0];
            REG_MIN_DIST: min_ff <= csr_write_data[MIN_W-1:0];
            REG_THRESHOLD: thr_ff <= csr_write_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Front stages.
   logic signed [W-1:0] crd_ff [NUM_ATOMS][3];
   logic v0_ff, p0_ff;
   logic [POS_W-1:0] pos_in [NUM_ATOMS];

   assign pos_in[0] = req_acceptor_carbon;
   assign pos_in[1] = req_acceptor_oxygen;
   assign pos_in[2] = req_donor_nitrogen;
   assign pos_in[3] = req_donor_hydrogen;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= start;
      p0_ff <= &req_atoms_present;
      for (int a = 0; a < NUM_ATOMS; a++) begin
         for (int k = 0; k < 3; k++) begin
            crd_ff[a][k] <= pos_in[a][k*W +: W];
         end
      end
   end

   logic [W-1:0] ad_ff [NUM_LANES][3];
   logic [SQ_W-1:0] sq_ff [NUM_LANES][3];
   logic v1_ff, p1_ff, v2_ff, p2_ff;
   logic signed [W:0] diff_in [NUM_LANES][3];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         for (int k = 0; k < 3; k++) begin
            diff_in[l][k] = (W+1)'(crd_ff[LANE_A[l]][k]) - (W+1)'(crd_ff[LANE_B[l]][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      p1_ff <= p0_ff;
      p2_ff <= p1_ff;
      for (int l = 0; l < NUM_LANES; l++) begin
         for (int k = 0; k < 3; k++) begin
            ad_ff[l][k] <= diff_in[l][k][W] ? W'(-diff_in[l][k]) : W'(diff_in[l][k]);
            sq_ff[l][k] <= SQ_W'(ad_ff[l][k]) * SQ_W'(ad_ff[l][k]);
         end
      end
   end

   // Sums and the close-contact test form stage zero of the root pipeline.
   logic [2*MIN_W-1:0] lim_in;
   logic [SW-1:0] ssum_in [NUM_LANES];
   logic close_in;

   always_comb begin
      lim_in = (2*MIN_W)'(min_ff) * (2*MIN_W)'(min_ff);
      close_in = 1'b0;
      for (int l = 0; l < NUM_LANES; l++) begin
         ssum_in[l] = SW'(sq_ff[l][0]) + SW'(sq_ff[l][1]) + SW'(sq_ff[l][2]);
         if (ssum_in[l] < SW'(lim_in) || ssum_in[l] == '0) close_in = 1'b1;
      end
   end

   logic sv_ff [D_BITS+1];
   logic sp_ff [D_BITS+1];
   logic sc_ff [D_BITS+1];
   logic [SW-1:0] ss_ff [D_BITS+1][NUM_LANES];
   logic [RW-1:0] srem_ff [D_BITS+1][NUM_LANES];
   logic [D_BITS-1:0] sroot_ff [D_BITS+1][NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else sv_ff[0] <= v2_ff;
      sp_ff[0] <= p2_ff;
      sc_ff[0] <= close_in;
      for (int l = 0; l < NUM_LANES; l++) begin
         ss_ff[0][l] <= ssum_in[l];
         srem_ff[0][l] <= '0;
         sroot_ff[0][l] <= '0;
      end
   end

   // One root bit per stage: bring down two bits of the square.
   for (genvar k = 0; k < D_BITS; k++) begin : g_root
      logic [RW-1:0] rem_in [NUM_LANES];
      logic [RW-1:0] trial_in [NUM_LANES];

      always_comb begin
         for (int l = 0; l < NUM_LANES; l++) begin
            rem_in[l] = {srem_ff[k][l][RW-3:0], ss_ff[k][l][SW-1 -: 2]};
            trial_in[l] = RW'({sroot_ff[k][l], 2'b01});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) sv_ff[k+1] <= 1'b0;
         else sv_ff[k+1] <= sv_ff[k];
         sp_ff[k+1] <= sp_ff[k];
         sc_ff[k+1] <= sc_ff[k];
         for (int l = 0; l < NUM_LANES; l++) begin
            ss_ff[k+1][l] <= {ss_ff[k][l][SW-3:0], 2'b00};
            if (rem_in[l] >= trial_in[l]) begin
               srem_ff[k+1][l] <= rem_in[l] - trial_in[l];
               sroot_ff[k+1][l] <= {sroot_ff[k][l][D_BITS-2:0], 1'b1};
            end else begin
               srem_ff[k+1][l] <= rem_in[l];
               sroot_ff[k+1][l] <= {sroot_ff[k][l][D_BITS-2:0], 1'b0};
            end
         end
      end
   end

   // Divider pipeline: one quotient bit per stage, rounded half up.
   logic dv_ff [NUM_W+1];
   logic dp_ff [NUM_W+1];
   logic dc_ff [NUM_W+1];
   logic [D_BITS-1:0] dd_ff [NUM_W+1][NUM_LANES];
   logic [NUM_W-1:0] dn_ff [NUM_W+1][NUM_LANES];
   logic [DR_W-1:0] drem_ff [NUM_W+1][NUM_LANES];
   logic [NUM_W-1:0] dq_ff [NUM_W+1][NUM_LANES];

   always_comb begin
      dv_ff[0] = sv_ff[D_BITS];
      dp_ff[0] = sp_ff[D_BITS];
      dc_ff[0] = sc_ff[D_BITS];
      for (int l = 0; l < NUM_LANES; l++) begin
         dd_ff[0][l] = sroot_ff[D_BITS][l];
         dn_ff[0][l] = {q_ff, 11'd0} >> 1;
         dn_ff[0][l] = dn_ff[0][l] + NUM_W'(sroot_ff[D_BITS][l] >> 1);
         drem_ff[0][l] = '0;
         dq_ff[0][l] = '0;
      end
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_div
      logic [DR_W-1:0] rsh_in [NUM_LANES];

      always_comb begin
         for (int l = 0; l < NUM_LANES; l++) begin
            rsh_in[l] = {drem_ff[k][l][DR_W-2:0], dn_ff[k][l][NUM_W-1]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1] <= 1'b0;
         else dv_ff[k+1] <= dv_ff[k];
         dp_ff[k+1] <= dp_ff[k];
         dc_ff[k+1] <= dc_ff[k];
         for (int l = 0; l < NUM_LANES; l++) begin
            dd_ff[k+1][l] <= dd_ff[k][l];
            dn_ff[k+1][l] <= {dn_ff[k][l][NUM_W-2:0], 1'b0};
            if (rsh_in[l] >= DR_W'(dd_ff[k][l])) begin
               drem_ff[k+1][l] <= rsh_in[l] - DR_W'(dd_ff[k][l]);
               dq_ff[k+1][l] <= {dq_ff[k][l][NUM_W-2:0], 1'b1};
            end else begin
               drem_ff[k+1][l] <= rsh_in[l];
               dq_ff[k+1][l] <= {dq_ff[k][l][NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   // Energy sum, saturation and the threshold test.
   logic signed [SUM_W-1:0] esum_in;
   logic signed [ENERGY_W-1:0] esat_in;
   logic out_v_ff, out_b_ff, out_c_ff;
   logic signed [ENERGY_W-1:0] out_e_ff;

   always_comb begin
      esum_in = SUM_W'(dq_ff[NUM_W][LANE_ON]) + SUM_W'(dq_ff[NUM_W][LANE_CH])
              - SUM_W'(dq_ff[NUM_W][LANE_OH]) - SUM_W'(dq_ff[NUM_W][LANE_CN]);
      if (esum_in > SUM_W'(E_MAX)) esat_in = E_MAX;
      else if (esum_in < SUM_W'(E_MIN)) esat_in = E_MIN;
      else esat_in = esum_in[ENERGY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else out_v_ff <= dv_ff[NUM_W];
      if (!dp_ff[NUM_W]) begin
         out_b_ff <= 1'b0;
         out_c_ff <= 1'b0;
         out_e_ff <= '0;
      end else if (dc_ff[NUM_W]) begin
         out_b_ff <= 1'b1;
         out_c_ff <= 1'b1;
         out_e_ff <= '0;
      end else begin
         out_b_ff <= esat_in < thr_ff;
         out_c_ff <= 1'b0;
         out_e_ff <= esat_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_bonded = out_b_ff;
   assign rsp_close_contact = out_c_ff;
   assign rsp_energy = out_e_ff;

endmodule
`default_nettype wire

### src/bhe_check.sv
// Port-level checker for the backbone hydrogen-bond energy block.
// Bound to backbone_hbond_energy_test; depends on bhe_pkg.
`default_nettype none
module bhe_check (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            busy,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_bonded,
   input wire logic                            rsp_close_contact,
   input wire logic signed [bhe_pkg::ENERGY_W-1:0] rsp_energy
);
   import bhe_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_close_bonded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_close_contact |-> rsp_bonded)
      else $error("close contact without bond");

   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_close_contact |-> rsp_energy == '0)
      else $error("close contact with energy");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind backbone_hbond_energy_test bhe_check u_bhe_check (
   .clock(clock),
   .reset(reset),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_bonded(rsp_bonded),
   .rsp_close_contact(rsp_close_contact),
   .rsp_energy(rsp_energy)
);
`default_nettype wire

### sim/backbone_hbond_energy_test_test.sv
// Testbench for the backbone hydrogen-bond energy block: directed and random atom pairs,
// predicted in a scoreboard class and checked result by result in order.
// Depends on bhe_pkg and the backbone_hbond_energy_test RTL.
`default_nettype none
module backbone_hbond_energy_test_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bhe_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct {
      logic bonded;
      logic close_contact;
      logic signed [ENERGY_W-1:0] energy;
   } hbond_type;

   class hbond_sb_type;
      hbond_type pending[$];
      longint unsigned q_factor;
      longint unsigned min_len;
      longint thresh;
      int mismatches;
      int checked;
      int close_seen;
      int bonded_seen;
      int missing_seen;

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_COULOMB: q_factor = v[Q_W-1:0];
            REG_MIN_DIST: min_len = v[MIN_W-1:0];
            REG_THRESHOLD: thresh = $signed(v[THR_W-1:0]);
            default: ;
         endcase
      endfunction

      function void defaults();
         q_factor = Q_RESET;
         min_len = MIN_RESET;
         thresh = THR_RESET;
      endfunction

      function longint coord(logic [POS_W-1:0] p, int k);
         logic signed [CW-1:0] c;
         c = p[k*CW +: CW];
         return longint'(c);
      endfunction

      function longint unsigned sqd(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
         longint unsigned s;
         longint d;
         s = 0;
         for (int k = 0; k < 3; k++) begin
            d = coord(a, k) - coord(b, k);
            if (d < 0) d = -d;
            s += longint'(d) * d;
         end
         return s;
      endfunction

      function longint unsigned root(longint unsigned s);
         longint unsigned r;
         longint unsigned bt;
         r = 0;
         bt = 64'd1 << 62;
         while (bt > s) bt >>= 2;
         while (bt != 0) begin
            if (s >= r + bt) begin
               s -= r + bt;
               r = (r >> 1) + bt;
            end else r >>= 1;
            bt >>= 2;
         end
         return r;
      endfunction

      function longint coul_term(longint unsigned s);
         longint unsigned d;
         d = root(s);
         return longint'(((q_factor << 10) + (d >> 1)) / d);
      endfunction

      function void note_word(logic [POS_W-1:0] c, logic [POS_W-1:0] o,
                              logic [POS_W-1:0] n, logic [POS_W-1:0] h,
                              logic [MASK_W-1:0] m);
         hbond_type r;
         longint unsigned s_on, s_oh, s_cn, s_ch, lim;
         longint e;
         r = '{1'b0, 1'b0, '0};
         if (m == 4'hF) begin
            s_on = sqd(o, n);
            s_oh = sqd(o, h);
            s_cn = sqd(c, n);
            s_ch = sqd(c, h);
            lim = min_len * min_len;
            if (s_on < lim || s_oh < lim || s_cn < lim || s_ch < lim ||
                s_on == 0 || s_oh == 0 || s_cn == 0 || s_ch == 0) begin
               r.bonded = 1;
               r.close_contact = 1;
               close_seen++;
            end else begin
               e = coul_term(s_on) + coul_term(s_ch) - coul_term(s_oh) - coul_term(s_cn);
               if (e > 131071) e = 131071;
               if (e < -131072) e = -131072;
               r.bonded = e < thresh;
               r.energy = e[ENERGY_W-1:0];
            end
         end else missing_seen++;
         if (r.bonded) bonded_seen++;
         pending.insert(pending.size(), r);
      endfunction

      function void check_word(logic b, logic cc, logic signed [ENERGY_W-1:0] en);
         hbond_type x;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word: %0b %0b %0d", b, cc, en);
            return;
         end
         x = pending.pop_front();
         if (x.bonded !== b || x.close_contact !== cc || x.energy !== en) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected bonded %0b close %0b energy %0d, got %0b %0b %0d",
                        x.bonded, x.close_contact, x.energy, b, cc, en);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, busy;
   logic [POS_W-1:0] req_acceptor_carbon = '0, req_acceptor_oxygen = '0;
   logic [POS_W-1:0] req_donor_nitrogen = '0, req_donor_hydrogen = '0;
   logic [MASK_W-1:0] req_atoms_present = '0;
   logic rsp_valid, rsp_bonded, rsp_close_contact;
   logic signed [ENERGY_W-1:0] rsp_energy;
   logic csr_write_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   int cycles = 0;
   bit calm = 0;
   hbond_sb_type sb = new();

   backbone_hbond_energy_test dut (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) sb.check_word(rsp_bonded, rsp_close_contact, rsp_energy);
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic send(logic [POS_W-1:0] c, logic [POS_W-1:0] o, logic [POS_W-1:0] n,
                       logic [POS_W-1:0] h, logic [MASK_W-1:0] m);
      while (!calm && $urandom_range(99) < 34) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_acceptor_carbon <= c;
      req_acceptor_oxygen <= o;
      req_donor_nitrogen <= n;
      req_donor_hydrogen <= h;
      req_atoms_present <= m;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(c, o, n, h, m);
      @(negedge clock);
   endtask

   function automatic logic [POS_W-1:0] pack(longint x, longint y, longint z);
      logic [CW-1:0] a, b, d;
      logic [POS_W-1:0] p;
      a = CW'(x); b = CW'(y); d = CW'(z);
      p = POS_W'({$urandom, $urandom});
      p[3*CW-1:0] = {a, b, d};
      return p;
   endfunction

   function automatic logic [POS_W-1:0] near(logic [POS_W-1:0] p, int span);
      return pack(sb.coord(p, 2) + $signed($urandom_range(2*span)) - span,
                  sb.coord(p, 1) + $signed($urandom_range(2*span)) - span,
                  sb.coord(p, 0) + $signed($urandom_range(2*span)) - span);
   endfunction

   function automatic logic [POS_W-1:0] rnd_pos();
      return POS_W'({$urandom, $urandom});
   endfunction

   // Geometry around a real backbone: O within 1300 of C and H within 1100 of N on each axis, N within span of O.
   task automatic send_backbone(int span);
      logic [POS_W-1:0] c, o, n, h;
      logic [MASK_W-1:0] m;
      c = pack($signed($urandom_range(40000)) - 20000, $signed($urandom_range(40000)) - 20000,
               $signed($urandom_range(40000)) - 20000);
      o = near(c, 1300);
      n = near(o, span);
      h = near(n, 1100);
      m = ($urandom_range(9) == 0) ? 4'($urandom) : 4'hF;
      send(c, o, n, h, m);
   endtask

   initial begin
      logic [POS_W-1:0] mx, mn, z;
      sb.defaults();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      mx = pack(524287, 524287, 524287);
      mn = pack(-524288, -524288, -524288);
      z = '0;
      send(mn, mx, mn, mx, 4'hF);
      send(mx, mn, mx, mn, 4'hF);
      send(z, pack(1200, 0, 0), pack(3000, 0, 0), pack(2000, 0, 0), 4'hF);
      send(z, pack(1200, 0, 0), pack(3000, 0, 0), pack(2000, 0, 0), 4'h7);
      for (int i = 0; i < 4; i++)
         send(rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), 4'hF ^ MASK_W'(1 << i));
      send(z, z, z, z, 4'h0);
      send(z, pack(100, 0, 0), pack(5000, 0, 0), pack(4000, 0, 0), 4'hF);
      send({POS_W{1'b1}}, {POS_W{1'b1}}, {POS_W{1'b1}}, {POS_W{1'b1}}, 4'hF);
      send(z, pack(1, 0, 0), pack(2, 0, 0), pack(3, 0, 0), 4'hF);
      drain();
      write_reg(REG_MIN_DIST, '0);
      write_reg(REG_COULOMB, CSR_DATA_W'(131071));
      write_reg(REG_THRESHOLD, 18'h1FFFF);
      send(z, z, pack(10, 0, 0), pack(20, 0, 0), 4'hF);
      send(z, pack(1, 0, 0), pack(2, 0, 0), pack(4, 0, 0), 4'hF);
      send(z, pack(1, 0, 0), pack(4, 0, 0), pack(2, 0, 0), 4'hF);
      send(mn, mx, mn, mx, 4'hF);
      drain();
      write_reg(REG_COULOMB, '0);
      write_reg(REG_MIN_DIST, CSR_DATA_W'(65535));
      write_reg(REG_THRESHOLD, 18'h20000);
      write_reg(REG_SPARE, 18'h3FFFF);
      send(mn, mx, mn, mx, 4'hF);
      send(z, pack(1200, 0, 0), pack(3000, 0, 0), pack(2000, 0, 0), 4'hF);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(REG_COULOMB, CSR_DATA_W'(Q_RESET));
               write_reg(REG_MIN_DIST, CSR_DATA_W'(MIN_RESET));
               write_reg(REG_THRESHOLD, THR_RESET);
            end
            1: write_reg(REG_MIN_DIST, '0);
            2: begin
               write_reg(REG_COULOMB, CSR_DATA_W'(131071));
               write_reg(REG_THRESHOLD, '0);
            end
            default: begin
               write_reg(REG_COULOMB, CSR_DATA_W'($urandom_range(131071)));
               write_reg(REG_MIN_DIST, CSR_DATA_W'($urandom_range(1500)));
               write_reg(REG_THRESHOLD, CSR_DATA_W'($urandom));
            end
         endcase
         calm = (ph == 2);
         for (int i = 0; i < 275; i++) begin
            if (ph == 4 && i == 100) begin
               start <= 0;
               while (sb.pending.size() != 0) @(negedge clock);
            end
            case ($urandom_range(9))
               0: send(rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), 4'($urandom));
               1: send_backbone(600);
               2, 3: send_backbone(8000);
               default: send_backbone(3500);
            endcase
         end
         calm = 0;
         drain();
      end
      $display("Checked %0d result words: %0d bonded, %0d close contacts, %0d missing atoms,",
               sb.checked, sb.bonded_seen, sb.close_seen, sb.missing_seen);
      $display("over six register settings including extremes of all three registers.");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d words still expected", sb.mismatches, sb.pending.size());
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
